[hdl/c65x_pkg.sv]
// shared types and constants for the 65c02 extended-instruction execute core
// no dependencies
`timescale 1ns / 1ps

package c65x_pkg;

  localparam int MEM_ADDR_BITS = 16;

  // request codes
  localparam logic [4:0] REQ_HOST_WR  = 5'd0;
  localparam logic [4:0] REQ_HOST_RD  = 5'd1;
  localparam logic [4:0] REQ_BRA      = 5'd2;
  localparam logic [4:0] REQ_BIT_IMM  = 5'd3;
  localparam logic [4:0] REQ_BIT_ZPX  = 5'd4;
  localparam logic [4:0] REQ_BIT_ABSX = 5'd5;
  localparam logic [4:0] REQ_TRB_ZP   = 5'd6;
  localparam logic [4:0] REQ_TRB_ABS  = 5'd7;
  localparam logic [4:0] REQ_TSB_ZP   = 5'd8;
  localparam logic [4:0] REQ_TSB_ABS  = 5'd9;
  localparam logic [4:0] REQ_RMB      = 5'd10;
  localparam logic [4:0] REQ_SMB      = 5'd11;
  localparam logic [4:0] REQ_BBR      = 5'd12;
  localparam logic [4:0] REQ_BBS      = 5'd13;
  localparam logic [4:0] REQ_STZ_ABS  = 5'd14;
  localparam logic [4:0] REQ_STZ_ABSX = 5'd15;
  localparam logic [4:0] REQ_STZ_ZP   = 5'd16;
  localparam logic [4:0] REQ_STZ_ZPX  = 5'd17;
  localparam logic [4:0] REQ_BRL      = 5'd18;
  localparam logic [4:0] REQ_JMP_IND  = 5'd19;

  // flag bit positions
  localparam int FL_N = 2;
  localparam int FL_V = 1;
  localparam int FL_Z = 0;

  typedef logic [MEM_ADDR_BITS-1:0] maddr_t;

  typedef struct packed {
    logic   en;
    maddr_t addr0;
    maddr_t addr1;
  } mem_rd_t;

  typedef struct packed {
    logic       en;
    maddr_t     addr;
    logic [7:0] data;
  } mem_wr_t;

  // item held in the execute stage
  typedef struct packed {
    logic [4:0]  req;
    logic [15:0] operand;
    logic [2:0]  bit_select;
    logic [7:0]  acc;
    logic [15:0] pc_in;
    logic [2:0]  flags_in;
    logic [7:0]  host_data;
  } exe_item_t;

  typedef struct packed {
    logic [2:0]  cycles_added;
    logic [7:0]  mem_byte;
    logic [2:0]  flags_out;
    logic [15:0] pc_out;
  } result_t;

endpackage

[hdl/c65x_mem.sv]
// byte memory with one write port, two registered read ports and
// forwarding of a write that lands on the same edge as a read; uses c65x_pkg
`timescale 1ns / 1ps

module c65x_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  c65x_pkg::mem_rd_t rd,
  input  c65x_pkg::mem_wr_t wr,
  output logic [7:0]        rdata0,
  output logic [7:0]        rdata1
);

  logic [7:0] mem [2**c65x_pkg::MEM_ADDR_BITS];
  logic [7:0] q0_r;
  logic [7:0] q1_r;
  logic [7:0] fwd_data_r;
  logic       hit0_r;
  logic       hit1_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      q0_r       <= mem[rd.addr0];
      q1_r       <= mem[rd.addr1];
      fwd_data_r <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit0_r <= 1'b0;
      hit1_r <= 1'b0;
    end else if (rd.en) begin
      hit0_r <= wr.en && (wr.addr == rd.addr0);
      hit1_r <= wr.en && (wr.addr == rd.addr1);
    end
  end

  assign rdata0 = hit0_r ? fwd_data_r : q0_r;
  assign rdata1 = hit1_r ? fwd_data_r : q1_r;

endmodule

[hdl/c65x_exec.sv]
// execute logic: flags, new pc, modified byte and cycle cost of one item
// uses c65x_pkg
`timescale 1ns / 1ps

module c65x_exec (
  input  c65x_pkg::exe_item_t item,
  input  logic [7:0]          rdata0,
  input  logic [7:0]          rdata1,
  output c65x_pkg::result_t   res,
  output logic                wr_en,
  output logic [7:0]          wr_data
);

  logic [7:0]  lo;
  logic [7:0]  mask;
  logic [15:0] off_lo;
  logic [15:0] off_hi;
  logic [15:0] pc2;
  logic [15:0] pc3;
  logic        z_imm;
  logic        z_mem;
  logic        bit_set;

  assign lo      = item.operand[7:0];
  assign mask    = 8'h01 << item.bit_select;
  assign off_lo  = {{8{lo[7]}}, lo};
  assign off_hi  = {{8{item.operand[15]}}, item.operand[15:8]};
  assign pc2     = item.pc_in + 16'd2;
  assign pc3     = item.pc_in + 16'd3;
  assign z_imm   = (item.acc & lo) == 8'h00;
  assign z_mem   = (item.acc & rdata0) == 8'h00;
  assign bit_set = (rdata0 & mask) != 8'h00;

  always_comb begin
    res.pc_out       = item.pc_in;
    res.flags_out    = item.flags_in;
    res.mem_byte     = 8'h00;
    res.cycles_added = 3'd0;
    wr_en            = 1'b0;
    wr_data          = 8'h00;
    unique case (item.req)
      c65x_pkg::REQ_HOST_WR: begin
        wr_en        = 1'b1;
        wr_data      = item.host_data;
        res.mem_byte = item.host_data;
      end
      c65x_pkg::REQ_HOST_RD: begin
        res.mem_byte = rdata0;
      end
      c65x_pkg::REQ_BRA: begin
        res.pc_out = pc2 + off_lo;
      end
      c65x_pkg::REQ_BIT_IMM: begin
        res.flags_out[c65x_pkg::FL_Z] = z_imm;
        res.mem_byte                  = lo;
        res.cycles_added              = 3'd2;
        res.pc_out                    = pc2;
      end
      c65x_pkg::REQ_BIT_ZPX, c65x_pkg::REQ_BIT_ABSX: begin
        res.flags_out[c65x_pkg::FL_Z] = z_mem;
        res.flags_out[c65x_pkg::FL_N] = rdata0[7];
        res.flags_out[c65x_pkg::FL_V] = rdata0[6];
        res.mem_byte                  = rdata0;
        res.cycles_added              = 3'd4;
        res.pc_out = (item.req == c65x_pkg::REQ_BIT_ZPX) ? pc2 : pc3;
      end
      c65x_pkg::REQ_TRB_ZP, c65x_pkg::REQ_TRB_ABS,
      c65x_pkg::REQ_TSB_ZP, c65x_pkg::REQ_TSB_ABS: begin
        res.flags_out[c65x_pkg::FL_Z] = z_mem;
        wr_en = 1'b1;
        if (item.req == c65x_pkg::REQ_TRB_ZP || item.req == c65x_pkg::REQ_TRB_ABS) begin
          wr_data = rdata0 & ~item.acc;
        end else begin
          wr_data = rdata0 | item.acc;
        end
        res.mem_byte = wr_data;
        if (item.req == c65x_pkg::REQ_TRB_ZP || item.req == c65x_pkg::REQ_TSB_ZP) begin
          res.cycles_added = 3'd5;
          res.pc_out       = pc2;
        end else begin
          res.cycles_added = 3'd6;
          res.pc_out       = pc3;
        end
      end
      c65x_pkg::REQ_RMB, c65x_pkg::REQ_SMB: begin
        wr_en            = 1'b1;
        wr_data          = (item.req == c65x_pkg::REQ_RMB) ? (rdata0 & ~mask)
                                                           : (rdata0 | mask);
        res.mem_byte     = wr_data;
        res.cycles_added = 3'd5;
        res.pc_out       = pc2;
      end
      c65x_pkg::REQ_BBR, c65x_pkg::REQ_BBS: begin
        res.mem_byte = rdata0;
        if (bit_set == (item.req == c65x_pkg::REQ_BBS)) begin
          res.pc_out = pc3 + off_hi;
        end else begin
          res.pc_out = pc3;
        end
      end
      c65x_pkg::REQ_STZ_ABS: begin
        wr_en            = 1'b1;
        res.cycles_added = 3'd4;
        res.pc_out       = pc3;
      end
      c65x_pkg::REQ_STZ_ABSX: begin
        wr_en            = 1'b1;
        res.cycles_added = 3'd5;
        res.pc_out       = pc3;
      end
      c65x_pkg::REQ_STZ_ZP: begin
        wr_en            = 1'b1;
        res.cycles_added = 3'd3;
        res.pc_out       = pc2;
      end
      c65x_pkg::REQ_STZ_ZPX: begin
        wr_en            = 1'b1;
        res.cycles_added = 3'd4;
        res.pc_out       = pc2;
      end
      c65x_pkg::REQ_BRL: begin
        res.pc_out = pc3 + item.operand;
      end
      c65x_pkg::REQ_JMP_IND: begin
        res.pc_out = {rdata1, rdata0};
      end
      default: begin
      end
    endcase
  end

endmodule

[hdl/cmos6502_extension_execute_core.sv]
// top level of the 65c02 extended-instruction execute core
// uses c65x_pkg, c65x_mem and c65x_exec
`timescale 1ns / 1ps

// channel  direction  ports                       item
// in_      slave      tvalid tready tdata tuser   request (tuser req_type)
// out_     master     tvalid tready tdata         pc, flags, byte, cycle cost
//
// one item a cycle sustained while out_tready is high; the memory read is taken
// on the accepting edge, execute and write-back run from the execute stage
// register, and the result is then held in the output register
// a write back and the next item's read on the same edge are forwarded
// rst_n clears the pipeline valids and the memory's forwarding hit flags only; the memory array holds no reset value
// a stalled output register holds the execute stage, which holds the input

module cmos6502_extension_execute_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] operand, [18:16] bit_select, [26:19] acc, [34:27] index_x,
  // [50:35] pc_in, [53:51] flags_in, [61:54] host_data, [63:62] zero
  input  logic [63:0] in_tdata,
  // [4:0] req_type
  input  logic [4:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] pc_out, [18:16] flags_out, [26:19] mem_byte, [29:27] cycles_added,
  // [31:30] zero
  output logic [31:0] out_tdata
);

  logic [4:0]  req;
  logic [15:0] arg;
  logic [7:0]  lo;
  logic [7:0]  idx;
  logic [7:0]  zpx;
  logic [15:0] absx;
  logic [15:0] addr;
  logic [15:0] addr1;
  logic        in_acc;
  logic        e_adv;

  c65x_pkg::exe_item_t e_item_r;
  c65x_pkg::maddr_t    e_addr_r;
  logic                e_valid_r;
  c65x_pkg::result_t   out_res_r;
  logic                out_valid_r;

  c65x_pkg::mem_rd_t   rd;
  c65x_pkg::mem_wr_t   wr;
  c65x_pkg::result_t   res;
  logic [7:0]          rdata0;
  logic [7:0]          rdata1;
  logic                wr_en;
  logic [7:0]          wr_data;

  assign req   = in_tuser;
  assign arg   = in_tdata[15:0];
  assign lo    = arg[7:0];
  assign idx   = in_tdata[34:27];
  assign zpx   = lo + idx;
  assign absx  = arg + {8'h00, idx};
  assign addr1 = absx + 16'd1;

  // address of the byte this item reads or writes
  always_comb begin
    unique case (req)
      c65x_pkg::REQ_BIT_ZPX, c65x_pkg::REQ_STZ_ZPX: addr = {8'h00, zpx};
      c65x_pkg::REQ_BIT_ABSX, c65x_pkg::REQ_STZ_ABSX,
      c65x_pkg::REQ_JMP_IND: addr = absx;
      c65x_pkg::REQ_TRB_ZP, c65x_pkg::REQ_TSB_ZP, c65x_pkg::REQ_RMB,
      c65x_pkg::REQ_SMB, c65x_pkg::REQ_BBR, c65x_pkg::REQ_BBS,
      c65x_pkg::REQ_STZ_ZP: addr = {8'h00, lo};
      default: addr = arg;
    endcase
  end

  assign e_adv     = !out_valid_r || out_tready;
  assign in_tready = !e_valid_r || e_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign rd.en    = in_acc;
  assign rd.addr0 = addr[c65x_pkg::MEM_ADDR_BITS-1:0];
  assign rd.addr1 = addr1[c65x_pkg::MEM_ADDR_BITS-1:0];

  assign wr.en   = e_valid_r && e_adv && wr_en;
  assign wr.addr = e_addr_r;
  assign wr.data = wr_data;

  c65x_mem u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd     (rd),
    .wr     (wr),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  c65x_exec u_exec (
    .item    (e_item_r),
    .rdata0  (rdata0),
    .rdata1  (rdata1),
    .res     (res),
    .wr_en   (wr_en),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        e_valid_r <= in_tvalid;
      end
      if (e_adv) begin
        out_valid_r <= e_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      e_item_r.req        <= req;
      e_item_r.operand    <= arg;
      e_item_r.bit_select <= in_tdata[18:16];
      e_item_r.acc        <= in_tdata[26:19];
      e_item_r.pc_in      <= in_tdata[50:35];
      e_item_r.flags_in   <= in_tdata[53:51];
      e_item_r.host_data  <= in_tdata[61:54];
      e_addr_r            <= addr[c65x_pkg::MEM_ADDR_BITS-1:0];
    end
    if (e_valid_r && e_adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r};

endmodule

[hdl/c65x_checker.sv]
// port-level checks for the 65c02 extended-instruction execute core
// bound to cmos6502_extension_execute_core; no package use
`timescale 1ns / 1ps

module c65x_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // output held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output item changed while stalled");

  // input only blocked by a full pipeline behind a stalled output
  a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input blocked without output back-pressure");

  // pipeline empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

  // cycle cost never above six
  a_cyc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[29:27] != 3'd7)
    else $error("cycle cost out of range");

  // no result after an idle input edge followed by an empty output
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tvalid ##1 !out_tvalid |=> !out_tvalid)
    else $error("result without an accepted item");

endmodule

bind cmos6502_extension_execute_core c65x_checker u_c65x_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
